// ===== design/qvr_pkg.sv =====
// Package: shared control type for the quaternion rotate pipeline.
package qvr_pkg;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic degen;
  } qvr_ctl_t;

endpackage

// ===== design/qvr_if.sv =====
// Interfaces: input and result channels of the quaternion rotate block.
interface qvr_in_if #(
  parameter int DW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] quat_w;
  logic signed [DW-1:0] quat_x;
  logic signed [DW-1:0] quat_y;
  logic signed [DW-1:0] quat_z;
  logic signed [DW-1:0] vec_x;
  logic signed [DW-1:0] vec_y;
  logic signed [DW-1:0] vec_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_out_if #(
  parameter int DW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] rot_x;
  logic signed [DW-1:0] rot_y;
  logic signed [DW-1:0] rot_z;
  logic                 degenerate;
  logic                 clipped;

  modport source (output valid, rot_x, rot_y, rot_z, degenerate, clipped, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, degenerate, clipped, output ready);
endinterface

// ===== design/quaternion_vector_rotate.sv =====
// Top level: streaming rotation of a 3-vector by a normalized quaternion.
// Takes one word per clock unless the output is held, and returns one result word
// per input word, in order: 2 stages form the products, squared norm |q|^2 and
// the unnormalized rotation matrix, 3 stages multiply by the vector and build the
// rounding dividend, DATA_WIDTH + 1 stages of restoring division (one quotient
// bit each, three lanes side by side) divide by |q|^2, and a last register
// saturates. The quaternion scale cancels, so any fixed-point format of q works.
// A zero quaternion passes the vector through and raises degenerate; a result
// outside the signed range saturates and raises clipped. The whole pipeline
// advances together and halts only while a result sits unread at the output.
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  qvr_in_if.sink    item,
  qvr_out_if.source result
);

  localparam int DW  = DATA_WIDTH;
  localparam int EW  = 2 * DW + 2;
  localparam int NW  = 2 * DW + 1;
  localparam int DNW = NW + 1;
  localparam int DVW = 3 * DW + 5;

  logic en;

  logic signed  [DW-1:0] vec_in  [3];
  qvr_ctl_t              ctl_m;
  logic         [NW-1:0] n_m;
  logic signed  [EW-1:0] m_m     [9];
  logic signed  [DW-1:0] vec_m   [3];

  qvr_ctl_t              ctl_x;
  logic        [DVW-1:0] dividend_x [3];
  logic        [DNW-1:0] den_x;
  logic                  neg_x   [3];
  logic signed  [DW-1:0] vec_x   [3];

  logic                  lane_valid [3];
  logic signed  [DW-1:0] lane_res   [3];
  logic                  lane_clip  [3];
  logic                  lane_degen [3];

  // one global advance: move unless the output word is held
  assign en         = !result.valid || result.ready;
  assign item.ready = en;

  assign vec_in[0] = item.vec_x;
  assign vec_in[1] = item.vec_y;
  assign vec_in[2] = item.vec_z;

  qvr_matrix #(.DW(DW)) u_matrix (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (item.valid),
    .qw       (item.quat_w),
    .qx       (item.quat_x),
    .qy       (item.quat_y),
    .qz       (item.quat_z),
    .vin      (vec_in),
    .ctl      (ctl_m),
    .n        (n_m),
    .m        (m_m),
    .vout     (vec_m)
  );

  qvr_xform #(.DW(DW)) u_xform (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl_m),
    .n_in     (n_m),
    .m        (m_m),
    .vin      (vec_m),
    .ctl      (ctl_x),
    .dividend (dividend_x),
    .den      (den_x),
    .neg      (neg_x),
    .vout     (vec_x)
  );

  // one divider lane per output component
  for (genvar r = 0; r < 3; r++) begin : g_lane
    qvr_div #(.DW(DW)) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl_x),
      .dividend (dividend_x[r]),
      .den_in   (den_x),
      .neg_in   (neg_x[r]),
      .vin      (vec_x[r]),
      .valid    (lane_valid[r]),
      .result   (lane_res[r]),
      .clip     (lane_clip[r]),
      .degen    (lane_degen[r])
    );
  end

  // lanes run in lockstep; lane 0 speaks for valid and degenerate, clipped ORs all three lanes
  assign result.valid      = lane_valid[0];
  assign result.rot_x      = lane_res[0];
  assign result.rot_y      = lane_res[1];
  assign result.rot_z      = lane_res[2];
  assign result.degenerate = lane_degen[0];
  assign result.clipped    = lane_clip[0] || lane_clip[1] || lane_clip[2];

  // identity path never saturates
  a_degen_no_clip: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |-> !result.clipped)
    else $error("clipped raised on a degenerate word");

  // input only backs up behind a held output word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("input blocked with empty output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule

// ===== design/qvr_matrix.sv =====
// Two stages: quaternion products, then squared norm and rotation matrix entries.
module qvr_matrix
  import qvr_pkg::*;
#(
  parameter  int DW = 16,
  localparam int PW = 2 * DW,
  localparam int EW = 2 * DW + 2,
  localparam int NW = 2 * DW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] qw,
  input  logic signed [DW-1:0] qx,
  input  logic signed [DW-1:0] qy,
  input  logic signed [DW-1:0] qz,
  input  logic signed [DW-1:0] vin [3],
  output qvr_ctl_t             ctl,
  output logic        [NW-1:0] n,
  output logic signed [EW-1:0] m [9],
  output logic signed [DW-1:0] vout [3]
);

  logic                 valid_a;
  logic signed [PW-1:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  logic signed [DW-1:0] vec_a [3];

  logic signed [EW-1:0] e_ww, e_xx, e_yy, e_zz, e_wx, e_wy, e_wz, e_xy, e_xz, e_yz;
  logic signed [EW-1:0] m_next [9];
  logic        [NW-1:0] n_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      ctl.valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= qw * qw;
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      wx <= qw * qx;
      wy <= qw * qy;
      wz <= qw * qz;
      xy <= qx * qy;
      xz <= qx * qz;
      yz <= qy * qz;
      vec_a <= vin;
      n         <= n_next;
      ctl.degen <= (n_next == '0);
      m         <= m_next;
      vout      <= vec_a;
    end
  end

  always_comb begin
    e_ww = EW'(ww);
    e_xx = EW'(xx);
    e_yy = EW'(yy);
    e_zz = EW'(zz);
    e_wx = EW'(wx);
    e_wy = EW'(wy);
    e_wz = EW'(wz);
    e_xy = EW'(xy);
    e_xz = EW'(xz);
    e_yz = EW'(yz);
    // all four squares are non-negative, so the sum fits unsigned
    n_next    = NW'(e_ww + e_xx + e_yy + e_zz);
    m_next[0] = (e_ww + e_xx) - (e_yy + e_zz);
    m_next[1] = (e_xy - e_wz) <<< 1;
    m_next[2] = (e_xz + e_wy) <<< 1;
    m_next[3] = (e_xy + e_wz) <<< 1;
    m_next[4] = (e_ww + e_yy) - (e_xx + e_zz);
    m_next[5] = (e_yz - e_wx) <<< 1;
    m_next[6] = (e_xz - e_wy) <<< 1;
    m_next[7] = (e_yz + e_wx) <<< 1;
    m_next[8] = (e_ww + e_zz) - (e_xx + e_yy);
  end

endmodule

// ===== design/qvr_xform.sv =====
// Three stages: matrix times vector, row sums, then magnitude and rounded dividend.
module qvr_xform
  import qvr_pkg::*;
#(
  parameter  int DW  = 16,
  localparam int EW  = 2 * DW + 2,
  localparam int NW  = 2 * DW + 1,
  localparam int PRW = EW + DW,
  localparam int SW  = PRW + 2,
  localparam int DVW = SW + 1,
  localparam int DNW = NW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  qvr_ctl_t             ctl_in,
  input  logic        [NW-1:0] n_in,
  input  logic signed [EW-1:0] m [9],
  input  logic signed [DW-1:0] vin [3],
  output qvr_ctl_t             ctl,
  output logic       [DVW-1:0] dividend [3],
  output logic       [DNW-1:0] den,
  output logic                 neg [3],
  output logic signed [DW-1:0] vout [3]
);

  qvr_ctl_t              ctl_c, ctl_d;
  logic signed [PRW-1:0] pr [9];
  logic         [NW-1:0] n_c, n_d;
  logic signed  [DW-1:0] vec_c [3];
  logic signed  [DW-1:0] vec_d [3];
  logic signed  [SW-1:0] sum [3];
  logic          [SW-1:0] mag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c.valid <= 1'b0;
      ctl_d.valid <= 1'b0;
      ctl.valid   <= 1'b0;
    end else if (en) begin
      ctl_c.valid <= ctl_in.valid;
      ctl_d.valid <= ctl_c.valid;
      ctl.valid   <= ctl_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_c.degen <= ctl_in.degen;
      ctl_d.degen <= ctl_c.degen;
      ctl.degen   <= ctl_d.degen;
      n_c   <= n_in;
      n_d   <= n_c;
      vec_c <= vin;
      vec_d <= vec_c;
      vout  <= vec_d;
      den   <= {n_d, 1'b0};
      for (int i = 0; i < 9; i++) begin
        pr[i] <= m[i] * vin[i % 3];
      end
      for (int r = 0; r < 3; r++) begin
        sum[r]      <= SW'(pr[3*r]) + SW'(pr[3*r+1]) + SW'(pr[3*r+2]);
        neg[r]      <= sum[r][SW-1];
        dividend[r] <= {mag[r], 1'b0} + DVW'(n_d);
      end
    end
  end

  // 2|s| + n over 2n gives round half away from zero
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag[r] = sum[r][SW-1] ? SW'(-sum[r]) : SW'(sum[r]);
    end
  end

endmodule

// ===== design/qvr_div.sv =====
// One divider lane: a quotient bit per stage, then saturation into the output register.
module qvr_div
  import qvr_pkg::*;
#(
  parameter  int DW  = 16,
  localparam int NW  = 2 * DW + 1,
  localparam int DNW = NW + 1,
  localparam int DVW = 3 * DW + 5,
  localparam int QW  = DW + 1,
  localparam int RW  = DNW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  qvr_ctl_t             ctl_in,
  input  logic       [DVW-1:0] dividend,
  input  logic       [DNW-1:0] den_in,
  input  logic                 neg_in,
  input  logic signed [DW-1:0] vin,
  output logic                 valid,
  output logic signed [DW-1:0] result,
  output logic                 clip,
  output logic                 degen
);

  localparam logic [QW-1:0] HALF    = QW'(1) << (DW - 1);
  localparam logic [QW-1:0] POS_MAX = HALF - QW'(1);

  // stage registers, one per quotient bit
  qvr_ctl_t              ctl  [1:QW];
  logic         [RW-1:0] rem  [1:QW];
  logic         [QW-1:0] lo   [1:QW];
  logic         [QW-1:0] quo  [1:QW];
  logic        [DNW-1:0] den  [1:QW];
  logic                  neg  [1:QW];
  logic signed  [DW-1:0] vec  [1:QW];

  // what each stage works on: lane input for stage zero, registers after
  qvr_ctl_t              at_ctl [QW];
  logic         [RW-1:0] at_rem [QW];
  logic         [QW-1:0] at_lo  [QW];
  logic         [QW-1:0] at_quo [QW];
  logic        [DNW-1:0] at_den [QW];
  logic                  at_neg [QW];
  logic signed  [DW-1:0] at_vec [QW];

  logic         [RW-1:0] trial [QW];
  logic                  ge    [QW];
  logic         [QW-1:0] qm;
  logic signed  [DW-1:0] result_next;
  logic                  clip_next;

  // partial remainder starts below the divisor
  always_comb begin
    at_ctl[0] = ctl_in;
    at_rem[0] = dividend[QW+RW-1:QW];
    at_lo[0]  = dividend[QW-1:0];
    at_quo[0] = '0;
    at_den[0] = den_in;
    at_neg[0] = neg_in;
    at_vec[0] = vin;
    for (int k = 1; k < QW; k++) begin
      at_ctl[k] = ctl[k];
      at_rem[k] = rem[k];
      at_lo[k]  = lo[k];
      at_quo[k] = quo[k];
      at_den[k] = den[k];
      at_neg[k] = neg[k];
      at_vec[k] = vec[k];
    end
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k] = {at_rem[k][RW-2:0], at_lo[k][QW-1]};
      ge[k]    = (trial[k] >= RW'(at_den[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= QW; k++) begin
        ctl[k].valid <= 1'b0;
      end
      valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) begin
        ctl[k+1] <= at_ctl[k];
        rem[k+1] <= ge[k] ? trial[k] - RW'(at_den[k]) : trial[k];
        lo[k+1]  <= at_lo[k] << 1;
        quo[k+1] <= {at_quo[k][QW-2:0], ge[k]};
        den[k+1] <= at_den[k];
        neg[k+1] <= at_neg[k];
        vec[k+1] <= at_vec[k];
      end
      valid  <= ctl[QW].valid;
      result <= result_next;
      clip   <= clip_next;
      degen  <= ctl[QW].degen;
    end
  end

  always_comb begin
    qm          = quo[QW];
    clip_next   = 1'b0;
    result_next = '0;
    if (ctl[QW].degen) begin
      result_next = vec[QW];
    end else if (!neg[QW]) begin
      if (qm > POS_MAX) begin
        result_next = DW'(POS_MAX);
        clip_next   = 1'b1;
      end else begin
        result_next = DW'(qm);
      end
    end else begin
      if (qm > HALF) begin
        result_next = DW'(-HALF);
        clip_next   = 1'b1;
      end else begin
        result_next = DW'(-qm);
      end
    end
  end

endmodule

// ===== dv/quaternion_vector_rotate_test.sv =====
// Testbench: quaternion vector rotate, directed table plus random words vs. exact predictor.
module quaternion_vector_rotate_test;

  localparam int DW = 16;
  localparam int LATENCY = DW + 7;
  localparam int N_RANDOM = 1300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [DW-1:0] field_t;

  // One input word.
  typedef struct {
    field_t qw, qx, qy, qz, vx, vy, vz;
  } rot_item_t;

  // One result word.
  typedef struct packed {
    field_t rx, ry, rz;
    logic   degen;
    logic   clip;
  } rot_result_t;

  // Directed row: input, and optionally a typed-in expected result.
  typedef struct {
    rot_item_t   stim;
    logic        has_exp;
    rot_result_t exp_res;
  } dir_row_t;

  logic clk;
  logic rst;

  qvr_in_if  #(.DW(DW)) item ();
  qvr_out_if #(.DW(DW)) result ();

  quaternion_vector_rotate #(.DATA_WIDTH(DW)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  rot_result_t pending_rot[$];
  int  err_count;
  int  words_in;
  int  words_out;
  int  degen_seen;
  int  clip_seen;
  int  idle_cycles;
  bit  stim_done;
  bit  no_idle;     // stretch with no idling on either side
  bit  hold_off;    // long receiver stall to fill the pipeline

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounded division of a signed numerator by positive n, half away from zero,
  // then saturated to the result width.
  function automatic field_t round_sat(input logic signed [95:0] num,
                                       input logic signed [95:0] n,
                                       ref logic clip);
    logic signed [95:0] mag;
    logic signed [95:0] q;
    logic signed [95:0] maxv;
    maxv = (96'sd1 <<< (DW - 1)) - 1;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + n) / (2 * n);
    if (num >= 0) begin
      if (q > maxv) begin
        q = maxv;
        clip = 1'b1;
      end
      return q[DW-1:0];
    end
    if (q > maxv + 1) begin
      q = maxv + 1;
      clip = 1'b1;
    end
    q = -q;
    return q[DW-1:0];
  endfunction

  // Rotated vector: exact M*v / |q|^2 with the unnormalized rotation matrix.
  function automatic rot_result_t rotate_vector(input rot_item_t it);
    rot_result_t r;
    logic signed [95:0] w, x, y, z, a, b, c, n;
    logic signed [95:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic clip;
    w = it.qw; x = it.qx; y = it.qy; z = it.qz;
    a = it.vx; b = it.vy; c = it.vz;
    n = w*w + x*x + y*y + z*z;
    clip = 1'b0;
    if (n == 0) begin
      r.rx = it.vx; r.ry = it.vy; r.rz = it.vz;
      r.degen = 1'b1;
      r.clip = 1'b0;
      return r;
    end
    m00 = w*w + x*x - y*y - z*z;
    m11 = w*w + y*y - x*x - z*z;
    m22 = w*w + z*z - x*x - y*y;
    m01 = 2 * (x*y - w*z);
    m10 = 2 * (x*y + w*z);
    m02 = 2 * (x*z + w*y);
    m20 = 2 * (x*z - w*y);
    m12 = 2 * (y*z - w*x);
    m21 = 2 * (y*z + w*x);
    r.rx = round_sat(m00*a + m01*b + m02*c, n, clip);
    r.ry = round_sat(m10*a + m11*b + m12*c, n, clip);
    r.rz = round_sat(m20*a + m21*b + m22*c, n, clip);
    r.degen = 1'b0;
    r.clip = clip;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH word %0d %s: got %0d want %0d", words_out, what, got, want);
    err_count++;
  endtask

  function automatic field_t rand_field();
    case ($urandom_range(0, 9))
      0: return field_t'(16'h8000);
      1: return field_t'(16'h7fff);
      2: return '0;
      3: return field_t'($urandom_range(0, 15)) - 8;
      default: return field_t'($urandom());
    endcase
  endfunction

  function automatic rot_item_t rand_item();
    rot_item_t it;
    int mode;
    mode = $urandom_range(0, 19);
    it.qw = rand_field(); it.qx = rand_field();
    it.qy = rand_field(); it.qz = rand_field();
    it.vx = rand_field(); it.vy = rand_field(); it.vz = rand_field();
    if (mode == 0) begin
      // zero quaternion: identity pass-through
      it.qw = '0; it.qx = '0; it.qy = '0; it.qz = '0;
    end else if (mode < 4) begin
      // w and x in Q1.14 range, y and z random; vx and vy at full scale
      it.qw = field_t'($urandom_range(0, 16384));
      it.qx = field_t'($urandom_range(0, 16384)) - 8192;
      it.vx = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      it.vy = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    end
    return it;
  endfunction

  function automatic rot_item_t mk(input int qw, qx, qy, qz, vx, vy, vz);
    rot_item_t it;
    it.qw = field_t'(qw); it.qx = field_t'(qx); it.qy = field_t'(qy);
    it.qz = field_t'(qz); it.vx = field_t'(vx); it.vy = field_t'(vy);
    it.vz = field_t'(vz);
    return it;
  endfunction

  function automatic rot_result_t mr(input int rx, ry, rz, input logic dg, cl);
    rot_result_t r;
    r.rx = field_t'(rx); r.ry = field_t'(ry); r.rz = field_t'(rz);
    r.degen = dg; r.clip = cl;
    return r;
  endfunction

  dir_row_t dir_table[$];

  task automatic build_table();
    rot_result_t none;
    none = mr(0, 0, 0, 1'b0, 1'b0);
    // zero quaternion: vector passes unchanged, extremes included
    dir_table.push_back('{mk(0, 0, 0, 0, 123, -456, 789), 1'b1,
                          mr(123, -456, 789, 1'b1, 1'b0)});
    dir_table.push_back('{mk(0, 0, 0, 0, -32768, 32767, -32768), 1'b1,
                          mr(-32768, 32767, -32768, 1'b1, 1'b0)});
    // identity quaternion in Q1.14
    dir_table.push_back('{mk(16384, 0, 0, 0, 1000, -2000, 3000), 1'b1,
                          mr(1000, -2000, 3000, 1'b0, 1'b0)});
    // unnormalized identity, any scale
    dir_table.push_back('{mk(1, 0, 0, 0, -32768, 32767, 0), 1'b1,
                          mr(-32768, 32767, 0, 1'b0, 1'b0)});
    // 180 degrees about x: y,z flip
    dir_table.push_back('{mk(0, 16384, 0, 0, 100, 200, 300), 1'b1,
                          mr(100, -200, -300, 1'b0, 1'b0)});
    // 180 about z with -32768 in y flips to +32768: clipped
    dir_table.push_back('{mk(0, 0, 0, 16384, 5, -32768, 7), 1'b1,
                          mr(-5, 32767, 7, 1'b0, 1'b1)});
    // full-scale quaternion components
    dir_table.push_back('{mk(-32768, 0, 0, 0, 11, 22, 33), 1'b1,
                          mr(11, 22, 33, 1'b0, 1'b0)});
    dir_table.push_back('{mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767), 1'b0, none});
    dir_table.push_back('{mk(32767, 32767, 32767, 32767, -32768, -32768, -32768), 1'b0, none});
    dir_table.push_back('{mk(32767, -32768, 32767, -32768, 32767, -32768, 32767), 1'b0, none});
    // 45 degrees about z (diagonal onto y), then 90 about z and about x: all saturate
    dir_table.push_back('{mk(15137, 0, 0, 6270, 32767, 32767, 0), 1'b0, none});
    dir_table.push_back('{mk(11585, 0, 0, 11585, 32767, -32768, 0), 1'b0, none});
    dir_table.push_back('{mk(11585, 11585, 0, 0, 0, -32768, -32768), 1'b0, none});
    // rounding ties and tiny quaternions
    dir_table.push_back('{mk(1, 1, 0, 0, 1, 1, 1), 1'b0, none});
    dir_table.push_back('{mk(1, 1, 1, 1, 3, -3, 5), 1'b0, none});
    dir_table.push_back('{mk(0, 0, -1, 0, -32768, 1, -1), 1'b0, none});
    dir_table.push_back('{mk(3, -4, 12, 0, 17, -17, 4), 1'b0, none});
  endtask

  // Sender: drives on the falling edge, holds until accepted.
  task automatic send_word(input rot_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid  <= 1'b1;
    item.quat_w <= it.qw; item.quat_x <= it.qx;
    item.quat_y <= it.qy; item.quat_z <= it.qz;
    item.vec_x  <= it.vx; item.vec_y  <= it.vy; item.vec_z <= it.vz;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    pending_rot.push_back(rotate_vector(it));
    words_in++;
    @(negedge clk);
  endtask

  // Receiver ready: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    result.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        result.ready <= no_idle || stim_done || ($urandom_range(0, 99) >= 28);
        @(negedge clk);
      end
    end
  end

  // Result checker, sampling at the rising edge.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (pending_rot.size() == 0) begin
        $display("MISMATCH unexpected result word %0d", words_out);
        err_count++;
      end else begin
        rot_result_t want;
        want = pending_rot.pop_front();
        if (result.rot_x !== want.rx) report_mismatch("rot_x", result.rot_x, want.rx);
        if (result.rot_y !== want.ry) report_mismatch("rot_y", result.rot_y, want.ry);
        if (result.rot_z !== want.rz) report_mismatch("rot_z", result.rot_z, want.rz);
        if (result.degenerate !== want.degen)
          report_mismatch("degenerate", result.degenerate, want.degen);
        if (result.clipped !== want.clip)
          report_mismatch("clipped", result.clipped, want.clip);
      end
      if (result.degenerate === 1'b1) degen_seen++;
      if (result.clipped === 1'b1) clip_seen++;
      words_out++;
    end
  end

  // Watchdog: cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("quaternion_vector_rotate_test failed");
      $finish;
    end
  end

  initial begin
    int k;
    rot_item_t it;
    rst = 1'b1;
    err_count = 0; words_in = 0; words_out = 0;
    degen_seen = 0; clip_seen = 0; idle_cycles = 0;
    stim_done = 1'b0; no_idle = 1'b0; hold_off = 1'b0;
    item.valid = 1'b0;
    item.quat_w = '0; item.quat_x = '0; item.quat_y = '0; item.quat_z = '0;
    item.vec_x = '0; item.vec_y = '0; item.vec_z = '0;
    build_table();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table; typed-in rows cross-check the predictor itself.
    foreach (dir_table[i]) begin
      if (dir_table[i].has_exp) begin
        rot_result_t p;
        p = rotate_vector(dir_table[i].stim);
        if (p !== dir_table[i].exp_res) begin
          $display("MISMATCH directed row %0d: predictor disagrees with table", i);
          err_count++;
        end
      end
      send_word(dir_table[i].stim);
    end

    // Random words; a quiet stretch, then a long receiver hold-off.
    for (k = 0; k < N_RANDOM; k++) begin
      no_idle = (k >= 300 && k < 500);
      if (k == 700) hold_off = 1'b1;
      it = rand_item();
      send_word(it);
    end
    item.valid <= 1'b0;
    stim_done = 1'b1;

    while (pending_rot.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    $display("covered %0d words in, %0d out: %0d zero-quaternion, %0d saturated",
             words_in, words_out, degen_seen, clip_seen);
    $display("with random gaps on both sides and a %0d-cycle output stall", HOLD_CYCLES);
    if (err_count == 0)
      $display("quaternion_vector_rotate_test passed");
    else
      $display("quaternion_vector_rotate_test failed");
    $finish;
  end

endmodule
